FILE: sv/che_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package che_pkg;

    // Parameter defaults
    localparam int BIN_COUNT_DEF  = 256;
    localparam int COUNT_BITS_DEF = 32;

    // Fixed field widths
    localparam int OUT_BITS = 32;

    // Item kinds
    localparam logic [1:0] KIND_ACC   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Channel select codes
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_ALPHA = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic       first_pixel;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] bin_index;
    } t_item;

    typedef struct packed {
        logic [OUT_BITS-1:0] bin_count;
        logic [OUT_BITS-1:0] largest_count;
    } t_result;

    // Classified command handed from front to back
    typedef struct packed {
        logic [1:0] kind;
        logic       first;
        logic       in_range;
        logic [7:0] bin;
    } t_cmd;

    // Back-end status seen by the front end
    typedef struct packed {
        logic clearing;
    } t_back_status;

    localparam int RESULT_BITS = $bits(t_result);
    localparam int CMD_BITS    = $bits(t_cmd);

endpackage

`default_nettype wire

FILE: sv/channel_histogram_engine.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel histogram engine. Each transfer on the item queue is an accumulate
// (the channel chosen by the configuration register picks one of BIN_COUNT
// bins, whose counter increments and saturates at COUNT_BITS ones), a bin
// read, or a bin clear; every item yields exactly one result transfer
// carrying the touched bin's count and the largest post-increment count
// seen since the last first_pixel item. The front end classifies items into
// a two-entry command queue and the back end runs a read-modify-write on
// a single-port bin memory: a read step reads the bin, then an execute
// step updates it and posts the result, waiting while the result queue
// is full. After reset the back end sweeps the bin memory to zero, one
// bin per cycle; full stays high during that pass while configuration
// writes are still taken. Write channel_select only when the engine is idle.
module channel_histogram_engine #(
    parameter int BIN_COUNT  = che_pkg::BIN_COUNT_DEF,
    parameter int COUNT_BITS = che_pkg::COUNT_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // item queue
    input  wire logic           push,
    output logic                full,
    input  wire che_pkg::t_item i_item,
    // result queue
    output logic                empty,
    input  wire logic           pop,
    output che_pkg::t_result    o_result,
    // configuration write channel
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [1:0]     i_cfg_data
);

    che_pkg::t_back_status status;
    che_pkg::t_cmd         cmd;
    logic                  cmd_valid;
    logic                  cmd_pop;
    logic                  res_full;
    logic                  res_push;
    che_pkg::t_result      res;
    logic [che_pkg::RESULT_BITS-1:0] res_q;

    // Front end: take items, select the bin byte, hold commands
    che_front #(
        .BIN_COUNT (BIN_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_status    (status),
        .i_cmd_pop   (cmd_pop),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // Back end: update bins and the tracker
    che_back #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_status    (status),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // Result queue: hold finished results until the consumer pops them
    che_fifo #(
        .WIDTH (che_pkg::RESULT_BITS)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_q)
    );

    assign o_result = che_pkg::t_result'(res_q);

endmodule

`default_nettype wire

FILE: sv/che_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-entry queue; a push while full is refused.
module che_fifo #(
    parameter int WIDTH = che_pkg::RESULT_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_data [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;
    logic             n_wptr;
    logic             n_rptr;
    logic [1:0]       n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_data[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wptr  = do_push ? ~r_wptr : r_wptr;
        n_rptr  = do_pop ? ~r_rptr : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: sv/che_front.sv
`timescale 1ns / 1ps
`default_nettype none

// Accept items, pick the bin byte, and queue classified commands.
module che_front #(
    parameter int BIN_COUNT = che_pkg::BIN_COUNT_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire che_pkg::t_item        i_item,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [1:0]            i_cfg_data,
    input  wire che_pkg::t_back_status i_status,
    input  wire logic                  i_cmd_pop,
    output logic                       o_cmd_valid,
    output che_pkg::t_cmd              o_cmd
);

    logic [1:0]    r_channel;
    logic [7:0]    sel_byte;
    logic [7:0]    cmd_byte;
    logic          q_full;
    logic          q_empty;
    logic          accept;
    che_pkg::t_cmd cmd_in;
    logic [che_pkg::CMD_BITS-1:0] q_out;

    assign o_cfg_ready = 1'b1;
    assign o_full      = q_full || i_status.clearing;
    assign accept      = i_push && !o_full;
    assign o_cmd_valid = !q_empty;
    assign o_cmd       = che_pkg::t_cmd'(q_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel <= che_pkg::CH_RED;
        end else if (i_cfg_valid) begin
            r_channel <= i_cfg_data;
        end
    end

    always_comb begin
        case (r_channel)
            che_pkg::CH_RED:   sel_byte = i_item.red;
            che_pkg::CH_GREEN: sel_byte = i_item.green;
            che_pkg::CH_BLUE:  sel_byte = i_item.blue;
            che_pkg::CH_ALPHA: sel_byte = i_item.alpha;
            default:           sel_byte = i_item.red;
        endcase
        cmd_byte = (i_item.kind == che_pkg::KIND_ACC) ? sel_byte : i_item.bin_index;
        cmd_in.kind     = i_item.kind;
        cmd_in.first    = i_item.first_pixel;
        cmd_in.bin      = cmd_byte;
        cmd_in.in_range = (32'(cmd_byte) < BIN_COUNT);
    end

    che_fifo #(
        .WIDTH (che_pkg::CMD_BITS)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (cmd_in),
        .o_full  (q_full),
        .i_pop   (i_cmd_pop),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

endmodule

`default_nettype wire

FILE: sv/che_back.sv
`timescale 1ns / 1ps
`default_nettype none

// Bin memory, read-modify-write sequencer and largest-count tracker.
module che_back #(
    parameter int BIN_COUNT  = che_pkg::BIN_COUNT_DEF,
    parameter int COUNT_BITS = che_pkg::COUNT_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cmd_valid,
    input  wire che_pkg::t_cmd    i_cmd,
    output logic                  o_cmd_pop,
    output che_pkg::t_back_status o_status,
    input  wire logic             i_res_full,
    output logic                  o_res_push,
    output che_pkg::t_result      o_res
);

    localparam int AW       = $clog2(BIN_COUNT);
    localparam int EXT_BITS = (COUNT_BITS > che_pkg::OUT_BITS) ? COUNT_BITS
                                                               : che_pkg::OUT_BITS;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [COUNT_BITS-1:0] r_mem [BIN_COUNT];
    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [AW-1:0]         r_clr_addr;
    che_pkg::t_cmd         r_cmd;
    logic [COUNT_BITS-1:0] r_rd_data;
    logic [COUNT_BITS-1:0] r_largest;
    logic [COUNT_BITS-1:0] n_largest;

    logic [COUNT_BITS-1:0] inc;
    logic [COUNT_BITS-1:0] base;
    logic [COUNT_BITS-1:0] count;
    logic                  upd;
    logic                  exec_go;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [COUNT_BITS-1:0] mem_din;
    logic [EXT_BITS-1:0]   count_ext;
    logic [EXT_BITS-1:0]   largest_ext;

    assign o_status.clearing = (r_state == S_CLEAR);
    assign o_cmd_pop  = (r_state == S_READ) && i_cmd_valid;
    assign exec_go    = (r_state == S_EXEC) && !i_res_full;
    assign o_res_push = exec_go;

    // Saturating increment and tracker base
    assign inc  = (&r_rd_data) ? r_rd_data : r_rd_data + COUNT_BITS'(1);
    assign base = r_cmd.first ? '0 : r_largest;

    always_comb begin
        count     = '0;
        n_largest = r_largest;
        upd       = 1'b0;
        mem_wdata = '0;
        case (r_cmd.kind)
            che_pkg::KIND_ACC: begin
                n_largest = base;
                if (r_cmd.in_range) begin
                    count     = inc;
                    upd       = 1'b1;
                    mem_wdata = inc;
                    if (inc > base) begin
                        n_largest = inc;
                    end
                end
            end
            che_pkg::KIND_READ: begin
                if (r_cmd.in_range) begin
                    count = r_rd_data;
                end
            end
            che_pkg::KIND_CLEAR: begin
                upd = r_cmd.in_range;
            end
            default: begin
                count = '0;
            end
        endcase
    end

    // The sweep after reset always writes zero, whatever command was last held
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_din   = '0;
        end else begin
            mem_we    = exec_go && upd;
            mem_waddr = AW'(r_cmd.bin);
            mem_din   = mem_wdata;
        end
    end

    assign count_ext          = EXT_BITS'(count);
    assign largest_ext        = EXT_BITS'(n_largest);
    assign o_res.bin_count     = count_ext[che_pkg::OUT_BITS-1:0];
    assign o_res.largest_count = largest_ext[che_pkg::OUT_BITS-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr_addr == AW'(BIN_COUNT - 1)) n_state = S_READ;
            S_READ:  if (i_cmd_valid) n_state = S_EXEC;
            S_EXEC:  if (!i_res_full) n_state = S_READ;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_largest  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (exec_go) begin
                r_largest <= n_largest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_din;
        end
        if (o_cmd_pop) begin
            r_rd_data <= r_mem[AW'(i_cmd.bin)];
        end
    end

    a_push_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (r_state == S_EXEC))
        else $error("result pushed outside execute step");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_cmd_pop)
        else $error("command taken during clear pass");

    a_track_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && !(r_cmd.kind == che_pkg::KIND_ACC && r_cmd.first))
        |=> (r_largest >= $past(r_largest)))
        else $error("largest count dropped without first pixel");

    a_exec_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state == S_EXEC))
        else $error("popped command not executed");

endmodule

`default_nettype wire
